// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/csr_pkg.sv -----
// Shared types, constants and helpers for the coefficient scan rank block.
// No dependencies.
package csr_pkg;

	localparam int MAX_LOG_BLOCKS = 5;
	localparam int LOG_W = 3;
	localparam int POS_W = 16;
	localparam int RANK_W = 16;
	localparam int TOTAL_W = POS_W + 1;
	localparam int COORD_W = 3 + MAX_LOG_BLOCKS;
	localparam int SUM_W = COORD_W + 1;
	localparam int IDX_W = 2 * MAX_LOG_BLOCKS;
	localparam int KEY_W = 1 + 2 * SUM_W;
	localparam int PAD_W = KEY_W - 1 - IDX_W;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	typedef logic [KEY_W-1:0] key_t;

	typedef enum logic {
		REG_LOG_BLOCKS_X = 1'b0,
		REG_LOG_BLOCKS_Y = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KEY,
		ST_SCAN,
		ST_HOLD
	} state_t;

	// Saturate a log block count at the supported maximum.
	function automatic logic [LOG_W-1:0] eff_log(input logic [LOG_W-1:0] v);
		eff_log = (v > LOG_W'(MAX_LOG_BLOCKS)) ? LOG_W'(MAX_LOG_BLOCKS) : v;
	endfunction

endpackage

// ----- hdl/csr_key_unit.sv -----
// Shared scan key unit: maps a row-major position to an unsigned sort key.
// Depends on csr_pkg.
module csr_key_unit (
	input  logic [csr_pkg::POS_W-1:0] position,
	input  logic [csr_pkg::LOG_W-1:0] lx,
	input  logic [csr_pkg::LOG_W-1:0] ly,
	output csr_pkg::key_t             key
);

	logic [csr_pkg::COORD_W-1:0] x;
	logic [csr_pkg::COORD_W-1:0] y;
	logic [csr_pkg::COORD_W-1:0] x_mask;
	logic [csr_pkg::LOG_W:0]     col_log;
	logic [csr_pkg::LOG_W-1:0]   lm;
	logic [csr_pkg::COORD_W-1:0] sx;
	logic [csr_pkg::COORD_W-1:0] sy;
	logic [csr_pkg::SUM_W-1:0]   s;
	logic [csr_pkg::SUM_W-1:0]   minor;
	logic                        low;
	logic [csr_pkg::IDX_W-1:0]   idx;
	logic [csr_pkg::POS_W-1:0]   y_full;

	always_comb begin
		// one bit wider than lx so that 5 + 3 does not wrap
		col_log = {1'b0, lx} + (csr_pkg::LOG_W+1)'(3);
		x_mask = ~({csr_pkg::COORD_W{1'b1}} << col_log);
		x      = position[csr_pkg::COORD_W-1:0] & x_mask;
		y_full = position >> col_log;
		y      = y_full[csr_pkg::COORD_W-1:0];
		lm     = (lx > ly) ? lx : ly;
		sx     = x << (lm - lx);
		sy     = y << (lm - ly);
		s      = {1'b0, sx} + {1'b0, sy};
		// odd diagonals run the other way
		minor  = s[0] ? ({1'b0, sy} - {1'b0, sx}) : ({1'b0, sx} - {1'b0, sy});
		low    = ((x >> lx) == '0) && ((y >> ly) == '0);
		idx    = (csr_pkg::IDX_W'(y) << lx) | csr_pkg::IDX_W'(x);
		// flip the sign bit so the signed minor orders as unsigned
		if (low) begin
			key = {1'b0, {csr_pkg::PAD_W{1'b0}}, idx};
		end else begin
			key = {1'b1, s, minor ^ {1'b1, {(csr_pkg::SUM_W-1){1'b0}}}};
		end
	end

endmodule

// ----- hdl/coeff_scan_rank.sv -----
// Top level of the coefficient scan rank block: config registers, sequencer, output register.
// Depends on csr_pkg and csr_key_unit.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------
//  input    | in_valid / in_stall   | position
//  output   | out_valid / out_stall | rank, out_of_range
//  config   | APB psel / penable    | paddr, pwdata, prdata
//
// Each item first computes the target key; then the shared key unit and comparator
// visit every block position once; out-of-range items skip the scan. in_stall is high
// from acceptance until the result is loaded into the output register. Reset clears
// both log registers to 0.
// A pending result waits in the output register while a new item is accepted.
module coeff_scan_rank (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csr_pkg::ADDR_W-1:0]  paddr,
	input  logic [csr_pkg::DATA_W-1:0]  pwdata,
	output logic [csr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [csr_pkg::POS_W-1:0]   position,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [csr_pkg::RANK_W-1:0]  rank,
	output logic                        out_of_range
);

	logic [csr_pkg::LOG_W-1:0]   log_blocks_x_q;
	logic [csr_pkg::LOG_W-1:0]   log_blocks_y_q;
	logic [csr_pkg::LOG_W-1:0]   lx;
	logic [csr_pkg::LOG_W-1:0]   ly;
	logic [csr_pkg::LOG_W:0]     area_log;
	logic [csr_pkg::TOTAL_W-1:0] total;
	logic [csr_pkg::TOTAL_W-1:0] total_m1;
	logic                        wr_en;
	csr_pkg::reg_idx_t           wr_idx;

	csr_pkg::state_t             state_q;
	csr_pkg::state_t             state_d;
	logic [csr_pkg::POS_W-1:0]   pos_q;
	logic [csr_pkg::POS_W-1:0]   cnt_q;
	logic [csr_pkg::RANK_W-1:0]  rank_q;
	logic                        oor_q;
	csr_pkg::key_t               tkey_q;
	logic                        out_valid_q;
	logic [csr_pkg::RANK_W-1:0]  rank_out_q;
	logic                        oor_out_q;

	logic [csr_pkg::POS_W-1:0]   ku_pos;
	csr_pkg::key_t               ku_key;
	logic                        is_less;
	logic                        is_last;
	logic                        pos_oor;
	logic                        out_free;
	logic                        load_out;
	logic                        latch_in;

	// configuration port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign wr_idx = csr_pkg::reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_blocks_x_q <= '0;
			log_blocks_y_q <= '0;
		end else if (wr_en) begin
			unique case (wr_idx)
				csr_pkg::REG_LOG_BLOCKS_X: log_blocks_x_q <= pwdata[csr_pkg::LOG_W-1:0];
				csr_pkg::REG_LOG_BLOCKS_Y: log_blocks_y_q <= pwdata[csr_pkg::LOG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (wr_idx)
			csr_pkg::REG_LOG_BLOCKS_X:
				prdata = csr_pkg::DATA_W'(log_blocks_x_q);
			csr_pkg::REG_LOG_BLOCKS_Y:
				prdata = csr_pkg::DATA_W'(log_blocks_y_q);
			default:
				prdata = '0;
		endcase
	end

	assign lx       = csr_pkg::eff_log(log_blocks_x_q);
	assign ly       = csr_pkg::eff_log(log_blocks_y_q);
	// widen the exponent so lx + ly up to 10 does not wrap
	assign area_log = {1'b0, lx} + {1'b0, ly};
	assign total    = csr_pkg::TOTAL_W'(64) << area_log;
	assign total_m1 = total - csr_pkg::TOTAL_W'(1);

	// shared key unit: target position first, then every scan position
	assign ku_pos = (state_q == csr_pkg::ST_KEY) ? pos_q : cnt_q;

	csr_key_unit u_key (
		.position (ku_pos),
		.lx       (lx),
		.ly       (ly),
		.key      (ku_key)
	);

	assign is_less  = ku_key < tkey_q;
	assign is_last  = cnt_q == total_m1[csr_pkg::POS_W-1:0];
	assign pos_oor  = {1'b0, pos_q} >= total;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		latch_in = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			csr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				latch_in = in_valid;
				if (in_valid) begin
					state_d = csr_pkg::ST_KEY;
				end
			end
			csr_pkg::ST_KEY: begin
				state_d = pos_oor ? csr_pkg::ST_HOLD : csr_pkg::ST_SCAN;
			end
			csr_pkg::ST_SCAN: begin
				if (is_last) begin
					state_d = csr_pkg::ST_HOLD;
				end
			end
			csr_pkg::ST_HOLD: begin
				// wait for the output register to drain
				if (out_free) begin
					load_out = 1'b1;
					state_d  = csr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = csr_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (latch_in) begin
			pos_q <= position;
		end
		unique case (state_q)
			csr_pkg::ST_KEY: begin
				tkey_q <= ku_key;
				cnt_q  <= '0;
				rank_q <= '0;
				oor_q  <= pos_oor;
			end
			csr_pkg::ST_SCAN: begin
				cnt_q <= cnt_q + csr_pkg::POS_W'(1);
				if (is_less) begin
					rank_q <= rank_q + csr_pkg::RANK_W'(1);
				end
			end
			default: ;
		endcase
		if (load_out) begin
			rank_out_q <= rank_q;
			oor_out_q  <= oor_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign rank         = rank_out_q;
	assign out_of_range = oor_out_q;

endmodule

// ----- hdl/csr_checker.sv -----
// Port-level checker for coeff_scan_rank, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module csr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] rank,
	input logic        out_of_range
);

	// a stalled result beat stays put
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(rank) && $stable(out_of_range))
	// one item at a time: the block is busy right after taking a beat
	`ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	// out-of-range results carry a zero rank
	`ASSERT_SAME(a_oor_rank_zero, out_valid && out_of_range, rank == 16'd0)

endmodule

bind coeff_scan_rank csr_checker u_csr_checker (.*);

// ----- verif/coeff_scan_rank_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for coeff_scan_rank: directed table, then random phases.
// Depends on csr_pkg and the coeff_scan_rank RTL.
module coeff_scan_rank_test;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int NUM_CASES = 25;
	localparam int NUM_PHASES = 6;
	localparam int PHASE_ITEMS = 13;

	typedef struct {
		logic [csr_pkg::POS_W-1:0]  pos;
		logic [csr_pkg::RANK_W-1:0] rank;
		logic                       oor;
	} scan_expect_t;

	typedef struct {
		logic [csr_pkg::LOG_W-1:0]  x_log;
		logic [csr_pkg::LOG_W-1:0]  y_log;
		logic [csr_pkg::POS_W-1:0]  pos;
		bit                         typed;
		logic [csr_pkg::RANK_W-1:0] rank;
		logic                       oor;
	} scan_case_t;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [csr_pkg::ADDR_W-1:0]   paddr;
	logic [csr_pkg::DATA_W-1:0]   pwdata;
	logic [csr_pkg::DATA_W-1:0]   prdata;
	logic                         pready;
	logic                         in_valid;
	logic                         in_stall;
	logic [csr_pkg::POS_W-1:0]    position;
	logic                         out_valid;
	logic                         out_stall;
	logic [csr_pkg::RANK_W-1:0]   rank;
	logic                         out_of_range;

	scan_expect_t                 expected_scans[$];
	logic [csr_pkg::LOG_W-1:0]    cur_x_log;
	logic [csr_pkg::LOG_W-1:0]    cur_y_log;
	int                           burst_left;
	int                           hold_len;
	int                           mismatches;
	int                           cycle_count;

	// Directed rows; rank/oor columns only count where typed is set.
	scan_case_t scan_cases [NUM_CASES] = '{
		'{3'd0, 3'd0, 16'd0,      1'b1, 16'd0,     1'b0},
		'{3'd0, 3'd0, 16'd63,     1'b1, 16'd63,    1'b0},
		'{3'd0, 3'd0, 16'd64,     1'b1, 16'd0,     1'b1},
		'{3'd0, 3'd0, 16'hFFFF,   1'b1, 16'd0,     1'b1},
		'{3'd0, 3'd0, 16'hAAAA,   1'b1, 16'd0,     1'b1},
		'{3'd0, 3'd0, 16'd1,      1'b0, 16'd0,     1'b0},
		'{3'd0, 3'd0, 16'd8,      1'b0, 16'd0,     1'b0},
		'{3'd0, 3'd0, 16'd9,      1'b0, 16'd0,     1'b0},
		'{3'd0, 3'd0, 16'd21,     1'b0, 16'd0,     1'b0},
		'{3'd1, 3'd0, 16'd1,      1'b0, 16'd0,     1'b0},
		'{3'd1, 3'd0, 16'd16,     1'b0, 16'd0,     1'b0},
		'{3'd1, 3'd0, 16'd127,    1'b1, 16'd127,   1'b0},
		'{3'd1, 3'd0, 16'd128,    1'b1, 16'd0,     1'b1},
		'{3'd0, 3'd2, 16'd24,     1'b0, 16'd0,     1'b0},
		'{3'd0, 3'd2, 16'd255,    1'b1, 16'd255,   1'b0},
		'{3'd0, 3'd2, 16'h5555,   1'b1, 16'd0,     1'b1},
		'{3'd5, 3'd0, 16'd31,     1'b0, 16'd0,     1'b0},
		'{3'd5, 3'd0, 16'd2047,   1'b1, 16'd2047,  1'b0},
		'{3'd5, 3'd0, 16'd2048,   1'b1, 16'd0,     1'b1},
		'{3'd0, 3'd5, 16'd8,      1'b0, 16'd0,     1'b0},
		'{3'd0, 3'd5, 16'd2047,   1'b1, 16'd2047,  1'b0},
		'{3'd7, 3'd6, 16'd0,      1'b1, 16'd0,     1'b0},
		'{3'd7, 3'd6, 16'h5555,   1'b0, 16'd0,     1'b0},
		'{3'd7, 3'd6, 16'hFFFF,   1'b1, 16'hFFFF,  1'b0},
		'{3'd0, 3'd0, 16'd36,     1'b0, 16'd0,     1'b0}
	};

	coeff_scan_rank uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.rank         (rank),
		.out_of_range (out_of_range)
	);

	function automatic int sat_log(input logic [csr_pkg::LOG_W-1:0] v);
		return (int'(v) > csr_pkg::MAX_LOG_BLOCKS) ? csr_pkg::MAX_LOG_BLOCKS : int'(v);
	endfunction

	// Two-part scan key; low-frequency corner sorts ahead of everything else.
	function automatic void zigzag_key(input int x, input int y, input int lx, input int ly,
			output int major, output int minor);
		int lm;
		int sx;
		int sy;
		if (x < (1 << lx) && y < (1 << ly)) begin
			major = -1;
			minor = y * (1 << lx) + x;
		end else begin
			lm = (lx > ly) ? lx : ly;
			sx = x << (lm - lx);
			sy = y << (lm - ly);
			major = sx + sy;
			minor = major[0] ? (sy - sx) : (sx - sy);
		end
	endfunction

	function automatic scan_expect_t predict_scan_rank(input logic [csr_pkg::POS_W-1:0] pos,
			input logic [csr_pkg::LOG_W-1:0] x_log, input logic [csr_pkg::LOG_W-1:0] y_log);
		scan_expect_t res;
		int lx;
		int ly;
		int cols;
		int rows;
		int t_major;
		int t_minor;
		int o_major;
		int o_minor;
		int smaller;
		lx = sat_log(x_log);
		ly = sat_log(y_log);
		cols = 8 << lx;
		rows = 8 << ly;
		res.pos = pos;
		res.rank = '0;
		res.oor = 1'b1;
		if (int'(pos) >= cols * rows)
			return res;
		zigzag_key(int'(pos) % cols, int'(pos) / cols, lx, ly, t_major, t_minor);
		smaller = 0;
		for (int y = 0; y < rows; y++) begin
			for (int x = 0; x < cols; x++) begin
				zigzag_key(x, y, lx, ly, o_major, o_minor);
				if (o_major < t_major || (o_major == t_major && o_minor < t_minor))
					smaller++;
			end
		end
		res.rank = csr_pkg::RANK_W'(smaller);
		res.oor = 1'b0;
		return res;
	endfunction

	task automatic idle_input(input int n);
		@(negedge clk);
		in_valid <= 1'b0;
		position <= csr_pkg::POS_W'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_position(input logic [csr_pkg::POS_W-1:0] pos, input bit typed,
			input scan_expect_t typed_res);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if ($urandom_range(0, 3) != 0)
				idle_input($urandom_range(1, 10));
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		position <= pos;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		if (typed)
			expected_scans.push_back(typed_res);
		else
			expected_scans.push_back(predict_scan_rank(pos, cur_x_log, cur_y_log));
	endtask

	// Drop valid and hold until every outstanding result has been taken.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_scans.size() != 0) @(posedge clk);
	endtask

	task automatic write_log_reg(input csr_pkg::reg_idx_t idx,
			input logic [csr_pkg::LOG_W-1:0] val);
		logic [csr_pkg::DATA_W-1:0] wdata;
		wdata = $urandom;
		wdata[csr_pkg::LOG_W-1:0] = val;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		if (idx == csr_pkg::REG_LOG_BLOCKS_X)
			cur_x_log = val;
		else
			cur_y_log = val;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_config(input logic [csr_pkg::LOG_W-1:0] x_log,
			input logic [csr_pkg::LOG_W-1:0] y_log);
		drain_results();
		write_log_reg(csr_pkg::REG_LOG_BLOCKS_X, x_log);
		write_log_reg(csr_pkg::REG_LOG_BLOCKS_Y, y_log);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver: randomly chosen free-running, random and heavy stall stretches, or a long hold when hold_len is set.
	initial begin
		int seg_kind;
		int seg_len;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_len != 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (hold_len - 1) @(negedge clk);
				hold_len = 0;
			end else begin
				seg_kind = $urandom_range(0, 2);
				seg_len = $urandom_range(4, 24);
				repeat (seg_len) begin
					@(negedge clk);
					case (seg_kind)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 1) == 1);
						default: out_stall <= ($urandom_range(0, 3) != 0);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		scan_expect_t exp_scan;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_scans.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none, actual rank %0d oor %b",
					$time, rank, out_of_range);
			end else begin
				exp_scan = expected_scans.pop_front();
				if (rank !== exp_scan.rank) begin
					mismatches++;
					$display("%0t: rank for position %0d, expected %0d, actual %0d",
						$time, exp_scan.pos, exp_scan.rank, rank);
				end
				if (out_of_range !== exp_scan.oor) begin
					mismatches++;
					$display("%0t: out_of_range for position %0d, expected %b, actual %b",
						$time, exp_scan.pos, exp_scan.oor, out_of_range);
				end
			end
		end
	end

	initial begin
		scan_expect_t typed_res;
		logic [csr_pkg::LOG_W-1:0] x_log;
		logic [csr_pkg::LOG_W-1:0] y_log;
		logic [csr_pkg::POS_W-1:0] pos;
		int total;
		int pick;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		position = '0;
		cur_x_log = '0;
		cur_y_log = '0;
		burst_left = 0;
		hold_len = 0;
		mismatches = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part; the first rows run on the reset values.
		for (int i = 0; i < NUM_CASES; i++) begin
			if (scan_cases[i].x_log != cur_x_log || scan_cases[i].y_log != cur_y_log)
				apply_config(scan_cases[i].x_log, scan_cases[i].y_log);
			typed_res.pos = scan_cases[i].pos;
			typed_res.rank = scan_cases[i].rank;
			typed_res.oor = scan_cases[i].oor;
			send_position(scan_cases[i].pos, scan_cases[i].typed, typed_res);
		end

		// Random phases; keep the block small so each scan stays short.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			do begin
				x_log = $urandom_range(0, 7);
				y_log = $urandom_range(0, 7);
			end while (sat_log(x_log) + sat_log(y_log) > 5);
			apply_config(x_log, y_log);
			total = 64 << (sat_log(x_log) + sat_log(y_log));
			// Long receiver hold-off so the output register and input both back up.
			if (ph == 1)
				hold_len = 3 * (total + 3) + 40;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					drain_results();
				pick = $urandom_range(0, 9);
				if (pick < 8)
					pos = csr_pkg::POS_W'($urandom_range(0, total - 1));
				else if (pick == 8)
					pos = csr_pkg::POS_W'($urandom_range(total, 65535));
				else
					pos = csr_pkg::POS_W'($urandom);
				send_position(pos, 1'b0, typed_res);
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- coeff_scan_rank.f -----
+incdir+hdl
hdl/csr_pkg.sv
hdl/csr_key_unit.sv
hdl/coeff_scan_rank.sv
hdl/csr_checker.sv
verif/coeff_scan_rank_test.sv
